FILE: hdl/sqt_pkg.sv
package sqt_pkg;

  // Count of kept characters, wide enough for a full store of 64.
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned SIDE_W = 4;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned CHAR_W = 8;

  // One classified input byte on its way from the front to the back.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              keep;
    logic              last;
  } sqt_item_t;

  // Everything a result carries besides the character itself.
  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic              gend;
    logic              last;
    logic              empty;
    logic              ovf;
  } sqt_meta_t;

  function automatic sqt_item_t sqt_classify(logic [CHAR_W-1:0] raw, logic last);
    sqt_item_t         it;
    logic [CHAR_W-1:0] c;
    c = raw;
    if (raw >= 8'h41 && raw <= 8'h5A) begin
      c = raw + 8'h20;
    end
    it.ch   = c;
    it.keep = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39);
    it.last = last;
    return it;
  endfunction

endpackage

FILE: hdl/sqt_ram.sv
module sqt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/sqt_front.sv
module sqt_front
  import sqt_pkg::*;
(
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_char_i,
  input  logic              is_last_i,
  input  logic              full_i,
  output logic              push_o,
  output sqt_item_t         item_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign item_o     = sqt_classify(in_char_i, is_last_i);

endmodule

FILE: hdl/sqt_fifo.sv
module sqt_fifo
  import sqt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sqt_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output sqt_item_t item_o
);

  sqt_item_t  slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

FILE: hdl/sqt_back.sv
module sqt_back
  import sqt_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              order_i,
  input  logic              empty_i,
  input  sqt_item_t         item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] out_char_o,
  output sqt_meta_t         meta_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SIDE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic [SIDE_W-1:0] side_q, side_d;
  logic [POS_W-1:0]  a_q, a_d;
  logic [POS_W-1:0]  b_q, b_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic              erun_q, erun_d;
  logic              pend_q, pend_d;
  sqt_meta_t         pmeta_q, pmeta_d;
  logic              oval_q, oval_d;
  logic [CHAR_W-1:0] ochar_q;
  sqt_meta_t         ometa_q;

  logic              we;
  logic              re;
  logic [CHAR_W-1:0] rdata;
  logic [CNT_W-1:0]  idx;
  logic [7:0]        sq;
  logic [SIDE_W-1:0] side_m1;
  logic              load_now;
  logic              issue_ok;
  logic              valid_pos;
  logic              done;
  logic              fin;
  logic              gend;

  assign side_m1 = side_q - 4'd1;
  assign sq      = {4'd0, side_q} * {4'd0, side_q};

  // Cipher order walks a column at a time, plain order a row at a time.
  always_comb begin
    if (order_i) begin
      idx = CNT_W'({4'd0, a_q} * {3'd0, side_q}) + CNT_W'(b_q);
    end else begin
      idx = CNT_W'({4'd0, b_q} * {3'd0, side_q}) + CNT_W'(a_q);
    end
  end

  assign valid_pos = erun_q || (idx < fill_q);
  assign done      = erun_q || ({1'b0, a_q} == side_m1 && {1'b0, b_q} == side_m1);
  assign fin       = erun_q || (k_q + 7'd1 == fill_q);

  always_comb begin
    if (order_i) begin
      gend = ({1'b0, b_q} == side_m1) && !fin;
    end else begin
      gend = (idx + CNT_W'(side_q) >= fill_q) && !fin;
    end
  end

  // The RAM holds its read data until the next read, so a fetched
  // character waits there until the output register is free.
  assign load_now = pend_q && (!oval_q || out_ready_i);
  assign issue_ok = !pend_q || load_now;
  assign re       = (state_q == ST_SCAN) && valid_pos && issue_ok;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign we       = pop_o && item_i.keep && (fill_q < CNT_W'(STORE_DEPTH));

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    side_d  = side_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    erun_d  = erun_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          if (we) begin
            fill_d = fill_q + 7'd1;
          end else if (item_i.keep) begin
            ovf_d = 1'b1;
          end
          if (item_i.last) begin
            state_d = ST_SIDE;
            side_d  = '0;
          end
        end
      end
      ST_SIDE: begin
        if ({1'b0, sq} < {1'b0, fill_q}) begin
          side_d = side_q + 4'd1;
        end else begin
          state_d = ST_SCAN;
          a_d     = '0;
          b_d     = '0;
          k_d     = '0;
          erun_d  = fill_q == '0;
        end
      end
      ST_SCAN: begin
        if (!valid_pos || issue_ok) begin
          if (re) begin
            k_d = k_q + 7'd1;
          end
          if (done) begin
            state_d = ST_IDLE;
            fill_d  = '0;
            ovf_d   = 1'b0;
          end else if ({1'b0, b_q} == side_m1) begin
            b_d = '0;
            a_d = a_q + 3'd1;
          end else begin
            b_d = b_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pend_d = re ? 1'b1 : (load_now ? 1'b0 : pend_q);
    oval_d = load_now ? 1'b1 : (out_ready_i ? 1'b0 : oval_q);
    pmeta_d = pmeta_q;
    if (re) begin
      pmeta_d.side  = side_q;
      pmeta_d.gend  = gend && !erun_q;
      pmeta_d.last  = fin;
      pmeta_d.empty = erun_q;
      pmeta_d.ovf   = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      side_q  <= '0;
      a_q     <= '0;
      b_q     <= '0;
      k_q     <= '0;
      erun_q  <= 1'b0;
      pend_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      side_q  <= side_d;
      a_q     <= a_d;
      b_q     <= b_d;
      k_q     <= k_d;
      erun_q  <= erun_d;
      pend_q  <= pend_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pmeta_q <= pmeta_d;
    if (load_now) begin
      ochar_q <= pmeta_q.empty ? '0 : rdata;
      ometa_q <= pmeta_q;
    end
  end

  sqt_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(fill_q[AW-1:0]),
    .wdata_i(item_i.ch),
    .re_i   (re),
    .raddr_i(idx[AW-1:0]),
    .rdata_o(rdata)
  );

  assign out_valid_o = oval_q;
  assign out_char_o  = ochar_q;
  assign meta_o      = ometa_q;

endmodule

FILE: hdl/square_transposition_cipher.sv
// Channel   Handshake                   Payload
// input     in_valid_i / in_ready_o     in_char_i, is_last_i
// output    out_valid_o / out_ready_i   out_char_o, square_side_o, group_end_o,
//                                       run_last_o, is_empty_o, overflowed_o
// config    cfg_valid_i / cfg_ready_o   cfg_data_i (output order)
//
// Input bytes are taken one a cycle while the two-entry queue has room, and
// kept bytes are stored one a cycle while the back end is collecting. A last
// byte starts a search for the side, then a walk over all side*side square
// positions through the store's single read port, positions past the count
// giving no result. Reset clears the control state only; the store needs no
// clearing. A stalled output holds the walk; the queue then holds the input.
module square_transposition_cipher
  import sqt_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic [3:0] square_side_o,
  output logic       group_end_o,
  output logic       run_last_o,
  output logic       is_empty_o,
  output logic       overflowed_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  logic      order_q;
  logic      full;
  logic      push;
  logic      pop;
  logic      empty;
  sqt_item_t fin_item;
  sqt_item_t fout_item;
  sqt_meta_t meta;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
    end else if (cfg_valid_i) begin
      order_q <= cfg_data_i;
    end
  end

  sqt_front u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_char_i (in_char_i),
    .is_last_i (is_last_i),
    .full_i    (full),
    .push_o    (push),
    .item_o    (fin_item)
  );

  sqt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (fin_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (fout_item)
  );

  sqt_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .order_i    (order_q),
    .empty_i    (empty),
    .item_i     (fout_item),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_char_o (out_char_o),
    .meta_o     (meta)
  );

  assign square_side_o = meta.side;
  assign group_end_o   = meta.gend;
  assign run_last_o    = meta.last;
  assign is_empty_o    = meta.empty;
  assign overflowed_o  = meta.ovf;

`ifndef NO_ASSERTIONS
  a_empty_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> run_last_o && square_side_o == 4'd0 && !group_end_o)
    else $error("empty result must be a lone final result with no side");

  a_no_gap_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_last_o |-> !group_end_o)
    else $error("final result must not mark a group end");

  a_side_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_empty_o |-> square_side_o != 4'd0 && square_side_o <= 4'd8)
    else $error("non-empty result must carry a side from one to eight");
`endif

endmodule

FILE: dv/tb_square_transposition_cipher.sv
module tb_square_transposition_cipher;
  import sqt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH   = 64;
  localparam logic        ORDER_CIPHER  = 1'b0;
  localparam logic        ORDER_PLAIN   = 1'b1;
  localparam int unsigned ITEM_TARGET   = 480;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [SIDE_W-1:0] side;
    logic              gend;
    logic              last;
    logic              empty;
    logic              ovf;
  } cipher_out_t;

  // Mirrors the block: keeps the folded message and, on its last byte, lays out
  // the characters that must come back and in which order.
  class square_scoreboard;
    logic [CHAR_W-1:0] msg_store [STORE_DEPTH];
    int unsigned       fill_count    = 0;
    bit                overflow_seen = 1'b0;
    logic              output_order  = ORDER_CIPHER;
    cipher_out_t       expected_chars [$];
    int unsigned       errors        = 0;

    function void push_char(logic [CHAR_W-1:0] ch, int unsigned side, bit gend, bit fin);
      cipher_out_t r;
      r.ch    = ch;
      r.side  = side[SIDE_W-1:0];
      r.gend  = gend;
      r.last  = fin;
      r.empty = 1'b0;
      r.ovf   = overflow_seen;
      expected_chars.push_back(r);
    endfunction

    function void note_char(logic [CHAR_W-1:0] raw, logic last);
      logic [CHAR_W-1:0] c;
      cipher_out_t       r;
      int unsigned       side;
      int unsigned       k;
      int unsigned       idx;
      c = raw;
      if (raw >= "A" && raw <= "Z") begin
        c = raw + 8'd32;
      end
      if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
        if (fill_count < STORE_DEPTH) begin
          msg_store[fill_count] = c;
          fill_count++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      if (!last) begin
        return;
      end
      if (fill_count == 0) begin
        r.ch    = '0;
        r.side  = '0;
        r.gend  = 1'b0;
        r.last  = 1'b1;
        r.empty = 1'b1;
        r.ovf   = overflow_seen;
        expected_chars.push_back(r);
      end else begin
        side = 0;
        while (side * side < fill_count) begin
          side++;
        end
        k = 0;
        if (output_order == ORDER_CIPHER) begin
          // Each column forms one group; positions past the count are skipped.
          for (int unsigned col = 0; col < side; col++) begin
            for (int unsigned row = 0; row < side; row++) begin
              idx = row * side + col;
              if (idx < fill_count) begin
                push_char(msg_store[idx], side,
                          ((row + 1) * side + col >= fill_count) && (k + 1 != fill_count),
                          k + 1 == fill_count);
                k++;
              end
            end
          end
        end else begin
          for (idx = 0; idx < fill_count; idx++) begin
            push_char(msg_store[idx], side,
                      ((idx + 1) % side == 0) && (idx + 1 != fill_count),
                      idx + 1 == fill_count);
          end
        end
      end
      fill_count    = 0;
      overflow_seen = 1'b0;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(cipher_out_t got);
      cipher_out_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual char %0h side %0d",
                 $time, got.ch, got.side);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      // The character carries no meaning on an empty message.
      if (!want.empty) begin
        compare_field("out_char", want.ch, got.ch);
      end
      compare_field("square_side", 8'(want.side), 8'(got.side));
      compare_field("group_end", 8'(want.gend), 8'(got.gend));
      compare_field("run_last", 8'(want.last), 8'(got.last));
      compare_field("is_empty", 8'(want.empty), 8'(got.empty));
      compare_field("overflowed", 8'(want.ovf), 8'(got.ovf));
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_char_i   = 8'h00;
  logic       is_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_char_o;
  logic [3:0] square_side_o;
  logic       group_end_o;
  logic       run_last_o;
  logic       is_empty_o;
  logic       overflowed_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i  = 1'b0;

  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  bit hold_req   = 1'b0;

  int unsigned items_sent = 0;

  square_scoreboard sb = new;

  square_transposition_cipher #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_char_i    (in_char_i),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .square_side_o(square_side_o),
    .group_end_o  (group_end_o),
    .run_last_o   (run_last_o),
    .is_empty_o   (is_empty_o),
    .overflowed_o (overflowed_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // This task drops valid only when a gap is drawn, so back-to-back bytes keep it high.
  task automatic send_item(input logic [7:0] ch, input logic last);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= ch;
    is_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_char(ch, last);
    items_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], i == s.len() - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // The back end may still be walking empty square positions after its last result.
  task automatic write_order(input logic order);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= order;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.output_order = order;
  endtask

  function automatic logic [7:0] alnum_byte();
    case ($urandom_range(0, 2))
      0:       return 8'("A" + $urandom_range(0, 25));
      1:       return 8'("a" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 70) return $urandom_range(1, 16);
    if (r < 85) return $urandom_range(17, 40);
    if (r < 95) return $urandom_range(41, 64);
    return $urandom_range(65, 75);
  endfunction

  // A message of len alphanumeric characters with random stray bytes mixed in.
  task automatic send_message(input int unsigned len);
    bit tail;
    tail = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      send_item(alnum_byte(), (i == len - 1) && !tail);
    end
    if (tail) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin : out_side
    int unsigned stall;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result({out_char_o, square_side_o, group_end_o, run_last_o,
                         is_empty_o, overflowed_o});
        stall = recv_burst ? 0 : $urandom_range(0, 3);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_square_transposition_cipher: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n_msgs;
    int unsigned len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, single character, byte extremes and the edges
    // of the letter and digit ranges.
    write_order(ORDER_CIPHER);
    send_item(" ", 1'b1);
    send_item("A", 1'b1);
    send_item(8'h00, 1'b0);
    send_item("Z", 1'b0);
    send_item("@", 1'b0);
    send_item("0", 1'b0);
    send_item("[", 1'b0);
    send_item("z", 1'b0);
    send_item(8'hFF, 1'b1);
    send_string("Ab1cD");
    write_order(ORDER_PLAIN);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b0);
    send_string("Nine8/`{:");

    phase = 0;
    while (phase < 4 || items_sent < ITEM_TARGET) begin
      write_order(phase < 2 ? phase[0] : logic'($urandom_range(0, 1)));
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      n_msgs     = $urandom_range(2, 4);
      if (phase == 2) begin
        // The receiver stalls while bytes keep coming, so the block backs up.
        hold_req   = 1'b1;
        send_burst = 1'b1;
      end
      for (int unsigned m = 0; m < n_msgs; m++) begin
        if (phase < 2 && m == 0) begin
          len = STORE_DEPTH;
        end else if (phase == 0 && m == 1) begin
          len = STORE_DEPTH + $urandom_range(1, 10);
        end else begin
          len = pick_len();
        end
        send_message(len);
        if (phase == 3 && m == 0) begin
          wait_drained();
        end
      end
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_square_transposition_cipher: done, clean");
    end else begin
      $display("tb_square_transposition_cipher: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sqt_pkg.sv
hdl/sqt_ram.sv
hdl/sqt_front.sv
hdl/sqt_fifo.sv
hdl/sqt_back.sv
hdl/square_transposition_cipher.sv
dv/tb_square_transposition_cipher.sv
